// ===== design/wbs_pkg.sv =====
// Package for the word break segmenter: default sizes and command codes.
// Depends on nothing; used by word_break_segmenter_top.
`timescale 1ns / 1ps

package wbs_pkg;

  // Default dictionary geometry.
  localparam int unsigned MaxWords   = 64;
  localparam int unsigned MaxWordLen = 16;

  localparam int unsigned CmdW  = 2;
  localparam int unsigned ByteW = 8;

  // Request commands.
  typedef enum logic [CmdW-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_DICT  = 2'd1,
    CMD_TEXT  = 2'd2,
    CMD_QUERY = 2'd3
  } cmd_e;

  // Sequencer states, one-hot.
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_DRAIN = 3'b100
  } state_e;

endpackage

// ===== design/word_break_segmenter_top.sv =====
// Top level of the word break segmenter: dictionary store, text window and scan sequencer.
// Depends on wbs_pkg for the default sizes, the command codes and the state type.
`timescale 1ns / 1ps

// Channel   Direction  Handshake               Payload
// in        input      in_valid_i/in_ready_o   cmd_i, ch_i, word_end_i
// out       output     out_valid_o/out_ready_i segmentable_o, dict_overflow_o
//
// Clear, dictionary byte and query requests finish in the idle state. A text byte request
// goes through the scan and drain states unless the dictionary is empty: the stored words
// are read from the row memory and checked by the single compare unit one word per cycle.
// Reset at once clears the counters, the window, the sticky flag and all reach bits but bit 0;
// the dictionary rows are not cleared, since only rows below the word count are ever read.
// A query result waits in the output register. While it waits, no request of any kind is
// taken unless the result is taken in the same cycle, so in_ready_o follows out_ready_i.

module word_break_segmenter_top #(
  parameter int unsigned MaxWords   = wbs_pkg::MaxWords,
  parameter int unsigned MaxWordLen = wbs_pkg::MaxWordLen
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [wbs_pkg::CmdW-1:0] cmd_i,
  input  logic [wbs_pkg::ByteW-1:0] ch_i,
  input  logic                     word_end_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     segmentable_o,
  output logic                     dict_overflow_o
);

  // Width of a word slot address, of the word count, of a stored length,
  // of the loading length (which saturates one above the maximum) and of a byte index.
  localparam int unsigned WaW  = (MaxWords > 1) ? $clog2(MaxWords) : 1;
  localparam int unsigned DcW  = $clog2(MaxWords + 1);
  localparam int unsigned LenW = $clog2(MaxWordLen + 1);
  localparam int unsigned LlW  = $clog2(MaxWordLen + 2);
  localparam int unsigned IdxW = (MaxWordLen > 1) ? $clog2(MaxWordLen) : 1;
  localparam int unsigned BW   = wbs_pkg::ByteW;

  typedef logic [MaxWordLen-1:0][BW-1:0] row_t;

  // Dictionary memories: one row of bytes and one length per word slot.
  row_t            dict_mem_q [MaxWords];
  logic [LenW-1:0] len_mem_q  [MaxWords];

  wbs_pkg::state_e state_q, state_d;
  logic [DcW-1:0]  dict_count_q, dict_count_d;
  logic [LlW-1:0]  load_len_q, load_len_d;
  logic            overflow_q, overflow_d;
  row_t            window_q, window_d;
  logic [MaxWordLen:0] reach_q, reach_d;
  logic [WaW-1:0]  scan_cnt_q, scan_cnt_d;
  logic            rd_vld_q;
  logic            hit_q, hit_d;
  row_t            row_q;
  logic [LenW-1:0] row_len_q;
  logic            out_valid_q, out_valid_d;
  logic            seg_q, seg_d;
  logic            ovf_out_q, ovf_out_d;

  logic            in_fire;
  wbs_pkg::cmd_e   cmd;
  logic            wr_en;
  logic [LlW-1:0]  load_len_inc;
  logic            len_wr_en;
  logic            match;
  logic            scan_last;
  logic [LenW-1:0] win_idx;

  assign cmd        = wbs_pkg::cmd_e'(cmd_i);
  assign in_ready_o = (state_q == wbs_pkg::ST_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;

  assign out_valid_o     = out_valid_q;
  assign segmentable_o   = seg_q;
  assign dict_overflow_o = ovf_out_q;

  // Dictionary byte bookkeeping. The byte lands only while the word still fits.
  assign load_len_inc = (load_len_q <= LlW'(MaxWordLen)) ? load_len_q + LlW'(1) : load_len_q;
  assign wr_en = in_fire && (cmd == wbs_pkg::CMD_DICT) &&
                 (load_len_q < LlW'(MaxWordLen)) && (dict_count_q < DcW'(MaxWords));
  assign len_wr_en = in_fire && (cmd == wbs_pkg::CMD_DICT) && word_end_i &&
                     (load_len_inc <= LlW'(MaxWordLen)) && (dict_count_q < DcW'(MaxWords));

  // The compare unit: the registered row against the newest bytes of the window.
  // Row byte i is the word's i-th byte; it lines up with window entry len-1-i.
  always_comb begin
    logic mism;
    mism    = 1'b0;
    win_idx = '0;
    for (int i = 0; i < MaxWordLen; i++) begin
      win_idx = LenW'(row_len_q - LenW'(1) - LenW'(i));
      if ((LenW'(i) < row_len_q) && (row_q[i] != window_q[win_idx[IdxW-1:0]])) begin
        mism = 1'b1;
      end
    end
    match = !mism && reach_q[LenW'(row_len_q - LenW'(1))];
  end

  assign scan_last = (DcW'(scan_cnt_q) + DcW'(1)) == dict_count_q;

  always_comb begin
    state_d      = state_q;
    dict_count_d = dict_count_q;
    load_len_d   = load_len_q;
    overflow_d   = overflow_q;
    window_d     = window_q;
    reach_d      = reach_q;
    scan_cnt_d   = scan_cnt_q;
    hit_d        = hit_q | (rd_vld_q & match);
    out_valid_d  = out_valid_q && !out_ready_i;
    seg_d        = seg_q;
    ovf_out_d    = ovf_out_q;

    unique case (state_q)
      wbs_pkg::ST_IDLE: begin
        if (in_fire) begin
          unique case (cmd)
            wbs_pkg::CMD_CLEAR: begin
              dict_count_d = '0;
              load_len_d   = '0;
            end
            wbs_pkg::CMD_DICT: begin
              load_len_d = load_len_inc;
              if (word_end_i) begin
                load_len_d = '0;
                if (len_wr_en) begin
                  dict_count_d = dict_count_q + DcW'(1);
                end else begin
                  overflow_d = 1'b1;
                end
              end
            end
            wbs_pkg::CMD_TEXT: begin
              for (int k = MaxWordLen - 1; k > 0; k--) begin
                window_d[k] = window_q[k-1];
              end
              window_d[0] = ch_i;
              scan_cnt_d  = '0;
              hit_d       = 1'b0;
              if (dict_count_q == '0) begin
                // No words: the new position cannot be reached.
                for (int k = MaxWordLen; k > 0; k--) begin
                  reach_d[k] = reach_q[k-1];
                end
                reach_d[0] = 1'b0;
              end else begin
                state_d = wbs_pkg::ST_SCAN;
              end
            end
            wbs_pkg::CMD_QUERY: begin
              out_valid_d = 1'b1;
              seg_d       = reach_q[0];
              ovf_out_d   = overflow_q;
              window_d    = '0;
              reach_d     = '0;
              reach_d[0]  = 1'b1;
            end
          endcase
        end
      end
      wbs_pkg::ST_SCAN: begin
        // One row read is issued per cycle; its compare follows in the next cycle.
        scan_cnt_d = scan_cnt_q + WaW'(1);
        if (scan_last) begin
          state_d = wbs_pkg::ST_DRAIN;
        end
      end
      wbs_pkg::ST_DRAIN: begin
        for (int k = MaxWordLen; k > 0; k--) begin
          reach_d[k] = reach_q[k-1];
        end
        reach_d[0] = hit_d;
        state_d    = wbs_pkg::ST_IDLE;
      end
      default: begin
        state_d = wbs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= wbs_pkg::ST_IDLE;
      dict_count_q <= '0;
      load_len_q   <= '0;
      overflow_q   <= 1'b0;
      window_q     <= '0;
      reach_q      <= {{MaxWordLen{1'b0}}, 1'b1};
      scan_cnt_q   <= '0;
      rd_vld_q     <= 1'b0;
      hit_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      dict_count_q <= dict_count_d;
      load_len_q   <= load_len_d;
      overflow_q   <= overflow_d;
      window_q     <= window_d;
      reach_q      <= reach_d;
      scan_cnt_q   <= scan_cnt_d;
      rd_vld_q     <= (state_q == wbs_pkg::ST_SCAN);
      hit_q        <= hit_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    seg_q     <= seg_d;
    ovf_out_q <= ovf_out_d;
  end

  // Dictionary memories: byte writes into the slot being loaded, registered row reads.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      dict_mem_q[dict_count_q[WaW-1:0]][load_len_q[IdxW-1:0]] <= ch_i;
    end
    if (len_wr_en) begin
      len_mem_q[dict_count_q[WaW-1:0]] <= LenW'(load_len_inc);
    end
    row_q     <= dict_mem_q[scan_cnt_q];
    row_len_q <= len_mem_q[scan_cnt_q];
  end

`ifndef SYNTHESIS
  // A result appears only right after a query was taken.
  a_out_from_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |->
      $past(in_valid_i && in_ready_o && (cmd_i == wbs_pkg::CMD_QUERY)))
    else $error("result raised without a query request");

  // The word count never passes the number of slots.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dict_count_q <= DcW'(MaxWords))
    else $error("word count beyond dictionary size");

  // The scan only reads filled slots.
  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == wbs_pkg::ST_SCAN) |-> (DcW'(scan_cnt_q) < dict_count_q))
    else $error("scan address past the stored words");

  // A text byte against a non-empty dictionary holds off the next request.
  a_text_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (cmd_i == wbs_pkg::CMD_TEXT) && (dict_count_q != '0))
      |=> !in_ready_o)
    else $error("request taken during a dictionary scan");
`endif

endmodule

// ===== dv/word_break_segmenter_top_test.sv =====
// Self-checking testbench for word_break_segmenter_top: a queue-fed request driver, a result
// monitor and a request-level predictor of the dictionary, text window and reach history.
// Depends on wbs_pkg and word_break_segmenter_top.
`timescale 1ns / 1ps

module word_break_segmenter_top_test;
  import wbs_pkg::*;

  // The run is stopped well past the slowest legal run: at least ItemTarget requests, each
  // with a scan over at most MaxWords words plus random gaps on both channels.
  localparam int unsigned CycleLimit  = 600000;
  localparam int unsigned ItemTarget  = 630;
  localparam int unsigned DrainCycles = MaxWords + 16;
  localparam int unsigned ByteMax     = 255;

  // One request as the driver presents it.
  typedef struct {
    cmd_e             cmd;
    logic [ByteW-1:0] ch;
    logic             word_end;
  } request_t;

  // One expected query answer.
  typedef struct {
    logic segmentable;
    logic dict_overflow;
  } verdict_t;

  // Clock, reset and the block's ports. Every input has a known value from time zero.
  logic             clk_i;
  logic             rst_ni          = 1'b0;
  logic             in_valid_i      = 1'b0;
  logic             in_ready_o;
  logic [CmdW-1:0]  cmd_i           = CMD_CLEAR;
  logic [ByteW-1:0] ch_i            = '0;
  logic             word_end_i      = 1'b0;
  logic             out_valid_o;
  logic             out_ready_i     = 1'b0;
  logic             segmentable_o;
  logic             dict_overflow_o;

  word_break_segmenter_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cmd_i          (cmd_i),
    .ch_i           (ch_i),
    .word_end_i     (word_end_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .segmentable_o  (segmentable_o),
    .dict_overflow_o(dict_overflow_o)
  );

  // Requests waiting to be driven, and query answers waiting to come out of the block.
  request_t pending_q[$];
  verdict_t verdict_q[$];
  request_t cur_req;
  int       accepted_count = 0;
  int       mismatch_count = 0;
  int       cycle_count    = 0;

  // Predictor state: the stored dictionary, the word being loaded, the text window with the
  // newest byte at index zero, the reach bits with the current position at bit zero, and
  // the sticky drop flag.
  logic [ByteW-1:0]  lex_bytes [MaxWords][MaxWordLen];
  int                lex_len   [MaxWords];
  int                lex_count;
  int                build_len;
  logic [ByteW-1:0]  text_tail [MaxWordLen];
  logic [MaxWordLen:0] reach_bits;
  logic              sticky_drop;

  // What the stimulus believes is stored, so that sentences can be built from real words.
  logic [ByteW-1:0]  menu_bytes [MaxWords][MaxWordLen];
  int                menu_len   [MaxWords];
  int                menu_n = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // ---------------------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------------------

  // Starting a new text: the window and all older reach bits are cleared, so no word can
  // match across the start, and the empty text itself is reachable.
  task automatic restart_text();
    for (int k = 0; k < MaxWordLen; k++) text_tail[k] = '0;
    reach_bits    = '0;
    reach_bits[0] = 1'b1;
  endtask

  task automatic predict_request(input request_t r);
    logic     hit;
    logic     same;
    int       len;
    verdict_t v;
    case (r.cmd)
      CMD_CLEAR: begin
        // Drops every word and a partly loaded one; the text and the sticky flag stay.
        lex_count = 0;
        build_len = 0;
      end
      CMD_DICT: begin
        if (build_len < MaxWordLen && lex_count < MaxWords) lex_bytes[lex_count][build_len] = r.ch;
        // The length saturates one past the maximum, which marks the word as overlong.
        if (build_len <= MaxWordLen) build_len++;
        if (r.word_end) begin
          if (build_len > MaxWordLen || lex_count >= MaxWords) begin
            sticky_drop = 1'b1;
          end else if (build_len > 0) begin
            lex_len[lex_count] = build_len;
            lex_count++;
          end
          build_len = 0;
        end
      end
      CMD_TEXT: begin
        for (int k = MaxWordLen - 1; k > 0; k--) text_tail[k] = text_tail[k-1];
        text_tail[0] = r.ch;
        hit = 1'b0;
        // A word of length len ends here if its start, len-1 positions back in the history
        // before the shift, was reachable and its bytes line up with the window.
        for (int w = 0; w < lex_count && !hit; w++) begin
          len = lex_len[w];
          if (reach_bits[len-1]) begin
            same = 1'b1;
            for (int i = 0; i < len; i++) begin
              if (lex_bytes[w][i] != text_tail[len-1-i]) same = 1'b0;
            end
            hit = same;
          end
        end
        reach_bits = {reach_bits[MaxWordLen-1:0], hit};
      end
      default: begin
        v.segmentable   = reach_bits[0];
        v.dict_overflow = sticky_drop;
        verdict_q.push_back(v);
        restart_text();
      end
    endcase
  endtask

  task automatic report_mismatch(input string what);
    $display("%0t ns: check failed: %s", $time, what);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------------------
  // Idling: each side drops its valid or ready at random, with a chance of 14 percent, except in a
  // stretch in the middle of the run where both run flat out.
  // ---------------------------------------------------------------------------------------
  function automatic logic idle_roll();
    if (accepted_count >= 250 && accepted_count < 400) return 1'b0;
    return $urandom_range(99) < 14;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Driver: presents the next pending request, holds it until accepted, and feeds every
  // accepted request to the predictor. Each output gets at most one assignment per edge.
  // ---------------------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : driver
    logic busy;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      cmd_i      <= CMD_CLEAR;
      ch_i       <= '0;
      word_end_i <= 1'b0;
    end else begin
      busy = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        predict_request(cur_req);
        accepted_count++;
        busy = 1'b0;
      end
      if (!busy) begin
        if (pending_q.size() != 0 && !idle_roll()) begin
          cur_req = pending_q.pop_front();
          in_valid_i <= 1'b1;
          cmd_i      <= cur_req.cmd;
          ch_i       <= cur_req.ch;
          word_end_i <= cur_req.word_end;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Monitor: every result taken is checked against the oldest expected answer.
  // ---------------------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    verdict_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (verdict_q.size() == 0) begin
          report_mismatch("result with no query outstanding");
        end else begin
          want = verdict_q.pop_front();
          if (segmentable_o !== want.segmentable)
            report_mismatch($sformatf("segmentable got %b want %b",
                                      segmentable_o, want.segmentable));
          if (dict_overflow_o !== want.dict_overflow)
            report_mismatch($sformatf("dict_overflow got %b want %b",
                                      dict_overflow_o, want.dict_overflow));
        end
      end
      out_ready_i <= !idle_roll();
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------------------
  task automatic push_req(input cmd_e c, input logic [ByteW-1:0] b, input logic we);
    request_t r;
    r.cmd      = c;
    r.ch       = b;
    r.word_end = we;
    pending_q.push_back(r);
  endtask

  // Clear and query requests carry random filler in the fields they ignore.
  task automatic push_ctl(input cmd_e c);
    push_req(c, ByteW'($urandom_range(ByteMax)), 1'($urandom_range(1)));
  endtask

  // A small alphabet makes matches and near misses common; 256 means any byte.
  function automatic logic [ByteW-1:0] pick_byte(input int alpha);
    if (alpha >= 256) return ByteW'($urandom_range(ByteMax));
    return ByteW'(8'h61 + $urandom_range(alpha - 1));
  endfunction

  // Loads one word and remembers it when the block is expected to keep it.
  task automatic add_word(input int len, input int alpha);
    logic [ByteW-1:0] b;
    for (int i = 0; i < len; i++) begin
      b = pick_byte(alpha);
      push_req(CMD_DICT, b, i == len - 1);
      if (i < MaxWordLen && menu_n < MaxWords) menu_bytes[menu_n][i] = b;
    end
    if (len <= MaxWordLen && menu_n < MaxWords) begin
      menu_len[menu_n] = len;
      menu_n++;
    end
  endtask

  // A well-formed text: a run of stored words, so the scan gets past many positions.
  task automatic say_sentence();
    int nw;
    int w;
    nw = $urandom_range(1, 6);
    for (int j = 0; j < nw; j++) begin
      w = $urandom_range(menu_n - 1);
      for (int i = 0; i < menu_len[w]; i++)
        push_req(CMD_TEXT, menu_bytes[w][i], 1'($urandom_range(1)));
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------------------
  initial begin : stimulus
    int alpha;
    int nw;
    int len;
    int nsent;
    int n;
    lex_count   = 0;
    build_len   = 0;
    sticky_drop = 1'b0;
    restart_text();

    // Directed part. An empty text is segmentable, even with an empty dictionary.
    push_req(CMD_QUERY, 8'hFF, 1'b1);
    // A byte with no words at all is not.
    push_req(CMD_TEXT, 8'h00, 1'b0);
    push_req(CMD_QUERY, 8'h00, 1'b0);
    // Extreme byte values as words, and a word that would only match if the zero bytes
    // before the start of the text counted.
    push_req(CMD_CLEAR, 8'hFF, 1'b1);
    push_req(CMD_DICT, 8'h00, 1'b1);
    push_req(CMD_DICT, 8'hFF, 1'b1);
    push_req(CMD_DICT, 8'h00, 1'b0);
    push_req(CMD_DICT, 8'h61, 1'b1);
    push_req(CMD_TEXT, 8'h61, 1'b1);
    push_req(CMD_QUERY, 8'h00, 1'b0);
    push_req(CMD_TEXT, 8'hFF, 1'b0);
    push_req(CMD_TEXT, 8'h00, 1'b1);
    push_req(CMD_TEXT, 8'h61, 1'b0);
    push_req(CMD_QUERY, 8'hFF, 1'b1);
    // A clear drops a half-loaded word; a duplicate word takes a slot of its own.
    push_req(CMD_DICT, 8'h78, 1'b0);
    push_req(CMD_CLEAR, 8'h00, 1'b0);
    push_req(CMD_DICT, 8'h79, 1'b1);
    push_req(CMD_DICT, 8'h79, 1'b1);
    push_req(CMD_TEXT, 8'h79, 1'b0);
    push_req(CMD_TEXT, 8'h79, 1'b1);
    push_req(CMD_QUERY, 8'h00, 1'b0);
    // The words from before the clear are gone.
    push_req(CMD_TEXT, 8'h00, 1'b0);
    push_req(CMD_QUERY, 8'h00, 1'b1);

    // Random part, in phases: load a dictionary, then a few texts, each ended by a query.
    // Phase one brings the longest and the overlong words; phase three fills the dictionary.
    for (int phase = 0; pending_q.size() < ItemTarget; phase++) begin
      alpha = ($urandom_range(9) == 0) ? 256 : $urandom_range(2, 4);
      if (phase == 1 || phase == 3 || $urandom_range(9) < 7) begin
        if ($urandom_range(4) == 0) push_req(CMD_DICT, pick_byte(alpha), 1'b0);
        push_ctl(CMD_CLEAR);
        menu_n = 0;
      end
      if (phase == 1) begin
        add_word(MaxWordLen, alpha);
        add_word(MaxWordLen + 1, alpha);
        add_word(MaxWordLen + 4, alpha);
        add_word(MaxWordLen - 1, alpha);
        add_word(1, alpha);
      end else if (phase == 3) begin
        for (int i = 0; i < MaxWords + 3; i++) add_word($urandom_range(1, 3), 3);
      end else begin
        nw = $urandom_range(1, 6);
        for (int i = 0; i < nw; i++) begin
          len = ($urandom_range(9) == 0) ? $urandom_range(1, MaxWordLen + 2)
                                         : $urandom_range(1, 4);
          add_word(len, alpha);
        end
      end
      nsent = $urandom_range(2, 5);
      for (int s = 0; s < nsent; s++) begin
        if ($urandom_range(9) < 7 && menu_n > 0) begin
          say_sentence();
        end else begin
          // Noise: random bytes, some from the dictionary's alphabet, some from anywhere.
          n = $urandom_range(0, 8);
          for (int i = 0; i < n; i++)
            push_req(CMD_TEXT, $urandom_range(1) ? pick_byte(alpha)
                                                 : ByteW'($urandom_range(ByteMax)),
                     1'($urandom_range(1)));
        end
        // Now and then a stray byte breaks an otherwise good text.
        if ($urandom_range(9) == 0) push_req(CMD_TEXT, pick_byte(alpha), 1'($urandom_range(1)));
        push_ctl(CMD_QUERY);
      end
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait until every request is in, every answer is out, and then long enough for a
    // stray result from a scan still in flight to show up.
    while (pending_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin : watchdog
    while (cycle_count < CycleLimit) @(posedge clk_i);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
